@@ src/point_in_triangle_test_assert.svh @@
// Assertion macros shared by the point-in-triangle checker.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef POINT_IN_TRIANGLE_TEST_ASSERT_SVH
`define POINT_IN_TRIANGLE_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PITT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("point_in_triangle_test check failed");

// Next-cycle implication, disabled while reset is high.
`define PITT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("point_in_triangle_test check failed");

`endif

@@ src/pitt_pkg.sv @@
// Shared widths, types, the cross-product term and the square-root step for the point-in-triangle test.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package pitt_pkg;

   localparam int CoordWidth    = 16;
   localparam int NormWidth     = 16;
   localparam int FieldWidth    = 48;
   localparam int ReqWidth      = 5 * FieldWidth;
   localparam int RspWidth      = 8;
   localparam int DiffWidth     = CoordWidth + 1;
   localparam int CrossWidth    = 2 * DiffWidth + 1;
   localparam int ProdWidth     = 2 * CrossWidth;
   localparam int DotWidth      = ProdWidth + 2;
   localparam int SqWidth       = ProdWidth;
   localparam int RootWidth     = SqWidth / 2;
   localparam int RemWidth      = RootWidth + 2;
   localparam int SumWidth      = CoordWidth + 3;
   localparam int FaceProdWidth = NormWidth + SumWidth;
   localparam int FaceWidth     = FaceProdWidth + 2;

   // Field offsets inside the request word.
   localparam int OffA = 0;
   localparam int OffB = FieldWidth;
   localparam int OffC = 2 * FieldWidth;
   localparam int OffN = 3 * FieldWidth;
   localparam int OffP = 4 * FieldWidth;

   // Bit positions inside the response word.
   localparam int HitBit    = 0;
   localparam int DegenBit  = 1;

   typedef struct packed {
      logic [RemWidth-1:0]  rem;
      logic [RootWidth-1:0] root;
   } sqrt_state_type;

   // One digit of the restoring integer square root: takes the next two
   // radicand bits and decides one root bit.
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s, logic [1:0] pair);
      logic [RemWidth-1:0] rem_sh;
      logic [RemWidth-1:0] trial;
      sqrt_state_type      r;
      rem_sh = {s.rem[RemWidth-3:0], pair};
      trial  = {s.root, 2'b01};
      if (rem_sh >= trial) begin
         r.rem  = rem_sh - trial;
         r.root = {s.root[RootWidth-2:0], 1'b1};
      end else begin
         r.rem  = rem_sh;
         r.root = {s.root[RootWidth-2:0], 1'b0};
      end
      return r;
   endfunction

   // One component of a cross product: a1*b2 - a2*b1.
   function automatic logic signed [CrossWidth-1:0] cross_term(
      logic signed [DiffWidth-1:0] a1, logic signed [DiffWidth-1:0] b2,
      logic signed [DiffWidth-1:0] a2, logic signed [DiffWidth-1:0] b1);
      logic signed [2*DiffWidth-1:0] p;
      logic signed [2*DiffWidth-1:0] q;
      p = a1 * b2;
      q = a2 * b1;
      return CrossWidth'(p) - CrossWidth'(q);
   endfunction

endpackage

`default_nettype wire

@@ src/point_in_triangle_test.sv @@
// Top level of the pipelined point-in-triangle test.
// Depends on pitt_pkg for widths, the cross-product term and the square-root step.
`timescale 1ns / 1ps
`default_nettype none

// Each request word carries a triangle (three vertices and a normal) and a query
// point; each response word says whether the point faces the triangle and lies
// inside it, and whether the triangle has zero area. The block takes one word per
// clock while no response is stalled, and returns exactly one response per
// request, in order. The pipeline has four arithmetic stages (edge vectors, cross
// products, 35x35 products, dot sums), 35 stages of a one-bit-per-stage integer square root, and the
// output register. The whole pipeline advances whenever the output register is
// empty or is being read, so req_tready follows rsp_tready; a stalled response
// holds every stage in place and nothing is lost or repeated. The facing test
// requires dot(n, a+b+c-3p) > 0, the two same-side tests accept zero, and the
// final test compares floor square roots of the barycentric magnitudes. A
// zero-area triangle reports degenerate and never a hit.
module point_in_triangle_test (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   // vertex_a[47:0], vertex_b[95:48], vertex_c[143:96],
   // face_normal[191:144], query_point[239:192]
   input  wire logic [pitt_pkg::ReqWidth-1:0] req_tdata,
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // hit[0], degenerate[1], zero[7:2]
   output      logic [pitt_pkg::RspWidth-1:0] rsp_tdata
);

   localparam int CW = pitt_pkg::CoordWidth;
   localparam int NW = pitt_pkg::NormWidth;
   localparam int DW = pitt_pkg::DiffWidth;
   localparam int XW = pitt_pkg::CrossWidth;
   localparam int PW = pitt_pkg::ProdWidth;
   localparam int TW = pitt_pkg::DotWidth;
   localparam int QW = pitt_pkg::SqWidth;
   localparam int RW = pitt_pkg::RootWidth;
   localparam int SW = pitt_pkg::SumWidth;
   localparam int FW = pitt_pkg::FaceProdWidth;
   localparam int GW = pitt_pkg::FaceWidth;

   // The whole pipeline moves together; it stops only when a response waits.
   logic adv;
   logic out_vld_ff;
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   // Stage 1: unpack, edge vectors and the centroid offset for the facing test.
   logic signed [CW-1:0] va [3];
   logic signed [CW-1:0] vb [3];
   logic signed [CW-1:0] vc [3];
   logic signed [CW-1:0] vp [3];
   logic signed [DW-1:0] u_in [3], u_ff [3];
   logic signed [DW-1:0] v_in [3], v_ff [3];
   logic signed [DW-1:0] w_in [3], w_ff [3];
   logic signed [SW-1:0] fsum_in [3], fsum_ff [3];
   logic signed [NW-1:0] nrm_in [3], nrm_ff [3];
   logic                 vld1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         va[i]      = $signed(req_tdata[pitt_pkg::OffA + i*CW +: CW]);
         vb[i]      = $signed(req_tdata[pitt_pkg::OffB + i*CW +: CW]);
         vc[i]      = $signed(req_tdata[pitt_pkg::OffC + i*CW +: CW]);
         vp[i]      = $signed(req_tdata[pitt_pkg::OffP + i*CW +: CW]);
         nrm_in[i]  = $signed(req_tdata[pitt_pkg::OffN + i*NW +: NW]);
         u_in[i]    = DW'(vb[i]) - DW'(va[i]);
         v_in[i]    = DW'(vc[i]) - DW'(va[i]);
         w_in[i]    = DW'(vp[i]) - DW'(va[i]);
         fsum_in[i] = SW'(va[i]) + SW'(vb[i]) + SW'(vc[i])
                    - (SW'(vp[i]) <<< 1) - SW'(vp[i]);
      end
   end

   // Stage 2: the three cross products and the facing products.
   logic signed [XW-1:0] vw_in [3], vw_ff [3];
   logic signed [XW-1:0] uw_in [3], uw_ff [3];
   logic signed [XW-1:0] uv_in [3], uv_ff [3];
   logic signed [FW-1:0] fprod_in [3], fprod_ff [3];
   logic                 vld2_ff;

   always_comb begin
      vw_in[0] = pitt_pkg::cross_term(v_ff[1], w_ff[2], v_ff[2], w_ff[1]);
      vw_in[1] = pitt_pkg::cross_term(v_ff[2], w_ff[0], v_ff[0], w_ff[2]);
      vw_in[2] = pitt_pkg::cross_term(v_ff[0], w_ff[1], v_ff[1], w_ff[0]);
      uw_in[0] = pitt_pkg::cross_term(u_ff[1], w_ff[2], u_ff[2], w_ff[1]);
      uw_in[1] = pitt_pkg::cross_term(u_ff[2], w_ff[0], u_ff[0], w_ff[2]);
      uw_in[2] = pitt_pkg::cross_term(u_ff[0], w_ff[1], u_ff[1], w_ff[0]);
      uv_in[0] = pitt_pkg::cross_term(u_ff[1], v_ff[2], u_ff[2], v_ff[1]);
      uv_in[1] = pitt_pkg::cross_term(u_ff[2], v_ff[0], u_ff[0], v_ff[2]);
      uv_in[2] = pitt_pkg::cross_term(u_ff[0], v_ff[1], u_ff[1], v_ff[0]);
      for (int i = 0; i < 3; i++) begin
         fprod_in[i] = FW'(nrm_ff[i]) * FW'(fsum_ff[i]);
      end
   end

   // Stage 3: component products of the five dot products, facing sign.
   // Dot 0 is vw.uv, 1 is uw.uv, 2 is uv.uv, 3 is vw.vw, 4 is uw.uw.
   // Since vu = -uv, dot(vw, vu) >= 0 is the same as dot(vw, uv) <= 0.
   logic signed [PW-1:0] pr_in [5][3], pr_ff [5][3];
   logic signed [GW-1:0] face_sum;
   logic                 face_in, face_ff;
   logic                 vld3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pr_in[0][i] = PW'(vw_ff[i]) * PW'(uv_ff[i]);
         pr_in[1][i] = PW'(uw_ff[i]) * PW'(uv_ff[i]);
         pr_in[2][i] = PW'(uv_ff[i]) * PW'(uv_ff[i]);
         pr_in[3][i] = PW'(vw_ff[i]) * PW'(vw_ff[i]);
         pr_in[4][i] = PW'(uw_ff[i]) * PW'(uw_ff[i]);
      end
      face_sum = GW'(fprod_ff[0]) + GW'(fprod_ff[1]) + GW'(fprod_ff[2]);
      face_in  = !face_sum[GW-1] && (face_sum != '0);
   end

   // Stage 4: dot sums, degenerate check and the sign tests.
   logic signed [TW-1:0] dot [5];
   logic                 degen_in, degen4_ff;
   logic                 pass_in, pass4_ff;
   logic [QW-1:0]        rad_in [3], rad_ff [3];
   logic                 vld4_ff;

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         dot[k] = TW'(pr_ff[k][0]) + TW'(pr_ff[k][1]) + TW'(pr_ff[k][2]);
      end
      degen_in  = (dot[2] == '0);
      pass_in   = !degen_in && face_ff && (dot[0][TW-1] || (dot[0] == '0))
                  && !dot[1][TW-1];
      // Lanes: vw magnitude, uw magnitude, uv magnitude.
      rad_in[0] = dot[3][QW-1:0];
      rad_in[1] = dot[4][QW-1:0];
      rad_in[2] = dot[2][QW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            u_ff[i]     <= u_in[i];
            v_ff[i]     <= v_in[i];
            w_ff[i]     <= w_in[i];
            fsum_ff[i]  <= fsum_in[i];
            nrm_ff[i]   <= nrm_in[i];
            vw_ff[i]    <= vw_in[i];
            uw_ff[i]    <= uw_in[i];
            uv_ff[i]    <= uv_in[i];
            fprod_ff[i] <= fprod_in[i];
            rad_ff[i]   <= rad_in[i];
            for (int k = 0; k < 5; k++) begin
               pr_ff[k][i] <= pr_in[k][i];
            end
         end
         face_ff   <= face_in;
         degen4_ff <= degen_in;
         pass4_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_tvalid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
      end
   end

   // Square-root stages: stage j decides root bit RW-1-j of all three lanes,
   // consuming the top two radicand bits and shifting the radicand left.
   logic [QW-1:0]            sx_ff  [RW][3];
   pitt_pkg::sqrt_state_type st_ff  [RW][3];
   logic                     sp_ff  [RW];
   logic                     sd_ff  [RW];
   logic                     sv_ff  [RW];

   for (genvar j = 0; j < RW; j++) begin : g_sqrt
      logic [QW-1:0]            x_src [3];
      pitt_pkg::sqrt_state_type s_src [3];
      logic                     p_src, d_src, v_src;

      if (j == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               x_src[l] = rad_ff[l];
               s_src[l] = '0;
            end
            p_src = pass4_ff;
            d_src = degen4_ff;
            v_src = vld4_ff;
         end
      end else begin : g_rest
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               x_src[l] = sx_ff[j-1][l];
               s_src[l] = st_ff[j-1][l];
            end
            p_src = sp_ff[j-1];
            d_src = sd_ff[j-1];
            v_src = sv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < 3; l++) begin
               sx_ff[j][l] <= {x_src[l][QW-3:0], 2'b00};
               st_ff[j][l] <= pitt_pkg::sqrt_step(s_src[l], x_src[l][QW-1 -: 2]);
            end
            sp_ff[j] <= p_src;
            sd_ff[j] <= d_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else if (adv) begin
            sv_ff[j] <= v_src;
         end
      end
   end

   // Output register: the barycentric magnitude test.
   logic [RW:0] root_sum;
   logic        hit_in, hit_ff, degen_ff;

   assign root_sum = {1'b0, st_ff[RW-1][0].root} + {1'b0, st_ff[RW-1][1].root};
   assign hit_in   = sp_ff[RW-1] && (root_sum <= {1'b0, st_ff[RW-1][2].root});

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff   <= hit_in;
         degen_ff <= sd_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= sv_ff[RW-1];
      end
   end

   always_comb begin
      rsp_tdata                     = '0;
      rsp_tdata[pitt_pkg::HitBit]   = hit_ff;
      rsp_tdata[pitt_pkg::DegenBit] = degen_ff;
   end
   assign rsp_tvalid = out_vld_ff;

endmodule

`default_nettype wire

@@ src/pitt_checker.sv @@
// Port-level checker for the point-in-triangle test, bound to the top level.
// Depends on pitt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "point_in_triangle_test_assert.svh"

module pitt_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [pitt_pkg::RspWidth-1:0] rsp_tdata
);

   logic rsp_stall;
   logic rsp_hit;
   logic rsp_degen;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_hit   = rsp_tdata[pitt_pkg::HitBit];
   assign rsp_degen = rsp_tdata[pitt_pkg::DegenBit];

   // A stalled response word stays and keeps its value.
   `PITT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // A degenerate triangle never reports a hit.
   `PITT_ASSERT_NOW(a_degen_no_hit, clock, reset, rsp_tvalid, !(rsp_hit && rsp_degen))

   // With the output register empty or draining, the block takes a new word.
   `PITT_ASSERT_NOW(a_ready_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready)

   // Padding bits of the response word stay zero.
   `PITT_ASSERT_NOW(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[pitt_pkg::RspWidth-1:2] == '0)

endmodule

bind point_in_triangle_test pitt_checker u_pitt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ sim/tb_point_in_triangle_test.sv @@
// Self-checking testbench for the pipelined point-in-triangle test.
// Depends on pitt_pkg and point_in_triangle_test; it needs no other file.
`timescale 1ns / 1ps

module tb_point_in_triangle_test;

   localparam int CycleLimit = 300000;
   localparam int DrainWait  = 80;    // comfortably past the pipeline latency
   localparam int LaneMax    = 32767;
   localparam int LaneMin    = -32768;

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   // vertex_a[47:0], vertex_b[95:48], vertex_c[143:96],
   // face_normal[191:144], query_point[239:192]
   logic [pitt_pkg::ReqWidth-1:0] req_tdata;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   // hit[0], degenerate[1], zero[7:2]
   logic [pitt_pkg::RspWidth-1:0] rsp_tdata;

   // Requests waiting to be driven, and verdicts waiting to come back.
   logic [pitt_pkg::ReqWidth-1:0] query_queue[$];
   logic [pitt_pkg::RspWidth-1:0] verdict_queue[$];

   int  error_count;
   int  cycle_count;
   int  burst_left;
   int  gap_left;
   int  stall_mode;
   int  mode_left;

   point_in_triangle_test u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Packs three signed lanes into one 48-bit field, x in the low bits.
   function automatic logic [pitt_pkg::FieldWidth-1:0] pack_lanes(longint x, longint y,
                                                                  longint z);
      logic [15:0] lx;
      logic [15:0] ly;
      logic [15:0] lz;
      lx = x[15:0];
      ly = y[15:0];
      lz = z[15:0];
      return {lz, ly, lx};
   endfunction

   // Sign-extends lane k of a 48-bit field.
   function automatic longint lane(logic [pitt_pkg::FieldWidth-1:0] f, int k);
      logic signed [15:0] s;
      s = f[16*k +: 16];
      return longint'(s);
   endfunction

   // Floor square root of a nonnegative value below 2^128.
   function automatic logic [63:0] floor_root(logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] cc;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c  = r | (64'd1 << b);
         cc = {64'd0, c} * {64'd0, c};
         if (cc <= x)
            r = c;
      end
      return r;
   endfunction

   // Exact three-term dot product of cross-product-sized vectors.
   function automatic logic signed [127:0] dot_wide(longint p[3], longint q[3]);
      logic signed [127:0] acc;
      logic signed [127:0] x;
      logic signed [127:0] y;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         x   = p[i];
         y   = q[i];
         acc = acc + x * y;
      end
      return acc;
   endfunction

   function automatic void cross_vec(longint p[3], longint q[3], output longint o[3]);
      o[0] = p[1] * q[2] - p[2] * q[1];
      o[1] = p[2] * q[0] - p[0] * q[2];
      o[2] = p[0] * q[1] - p[1] * q[0];
   endfunction

   // Expected response word for one request word.
   function automatic logic [pitt_pkg::RspWidth-1:0] classify_query(
      logic [pitt_pkg::ReqWidth-1:0] word);
      longint a[3], b[3], c[3], n[3], p[3];
      longint u[3], v[3], w[3];
      longint vw[3], vu[3], uw[3], uv[3];
      longint facing;
      logic signed [127:0] area_sq;
      logic [63:0] bary_sum;
      logic hit;
      logic degen;
      facing = 0;
      hit    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         a[i] = lane(word[pitt_pkg::OffA +: pitt_pkg::FieldWidth], i);
         b[i] = lane(word[pitt_pkg::OffB +: pitt_pkg::FieldWidth], i);
         c[i] = lane(word[pitt_pkg::OffC +: pitt_pkg::FieldWidth], i);
         n[i] = lane(word[pitt_pkg::OffN +: pitt_pkg::FieldWidth], i);
         p[i] = lane(word[pitt_pkg::OffP +: pitt_pkg::FieldWidth], i);
         u[i] = b[i] - a[i];
         v[i] = c[i] - a[i];
         w[i] = p[i] - a[i];
         facing += n[i] * (a[i] + b[i] + c[i] - 3 * p[i]);
      end
      cross_vec(v, w, vw);
      cross_vec(v, u, vu);
      cross_vec(u, w, uw);
      cross_vec(u, v, uv);
      area_sq = dot_wide(uv, uv);
      degen   = (area_sq == 0);
      // Facing must be strictly positive; the same-side tests accept zero.
      if (!degen && facing > 0 && dot_wide(vw, vu) >= 0 && dot_wide(uw, uv) >= 0) begin
         bary_sum = floor_root(dot_wide(vw, vw)) + floor_root(dot_wide(uw, uw));
         hit      = (bary_sum <= floor_root(area_sq));
      end
      return {6'd0, degen, hit};
   endfunction

   function automatic longint clamp_lane(longint x);
      if (x > LaneMax)
         return LaneMax;
      if (x < LaneMin)
         return LaneMin;
      return x;
   endfunction

   function automatic longint rand_lane(int span);
      return longint'($urandom_range(2 * span, 0)) - span;
   endfunction

   function automatic logic [pitt_pkg::FieldWidth-1:0] rand_field();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[pitt_pkg::FieldWidth-1:0];
   endfunction

   task automatic add_query(logic [pitt_pkg::FieldWidth-1:0] a,
                            logic [pitt_pkg::FieldWidth-1:0] b,
                            logic [pitt_pkg::FieldWidth-1:0] c,
                            logic [pitt_pkg::FieldWidth-1:0] n,
                            logic [pitt_pkg::FieldWidth-1:0] p);
      query_queue.insert(query_queue.size(), {p, n, c, b, a});
   endtask

   // A triangle with a point near its surface and a normal turned toward the
   // centroid, so that most of these get through to the barycentric test.
   task automatic add_shaped_query();
      longint a[3], b[3], c[3], n[3], p[3];
      longint facing;
      int span;
      int scale;
      int s;
      int t;
      case ($urandom_range(9, 0))
         0:       span = LaneMax / 2;
         1, 2:    span = 2000;
         default: span = 200;
      endcase
      scale  = 64;
      s      = $urandom_range(scale, 0);
      t      = $urandom_range(scale + 8, 0);
      facing = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = rand_lane(span);
         b[i] = rand_lane(span);
         c[i] = rand_lane(span);
         n[i] = rand_lane(16383);
      end
      for (int i = 0; i < 3; i++) begin
         p[i] = clamp_lane(a[i] + (s * (b[i] - a[i]) + t * (c[i] - a[i])) / scale
                           + rand_lane(4));
         facing += n[i] * (a[i] + b[i] + c[i] - 3 * p[i]);
      end
      if (facing < 0) begin
         for (int i = 0; i < 3; i++)
            n[i] = -n[i];
      end
      add_query(pack_lanes(a[0], a[1], a[2]), pack_lanes(b[0], b[1], b[2]),
                pack_lanes(c[0], c[1], c[2]), pack_lanes(n[0], n[1], n[2]),
                pack_lanes(p[0], p[1], p[2]));
   endtask

   // Sender: bursts of random length separated by random gaps. The word at
   // the head of the queue is held until the block takes it, and its verdict
   // is queued at that same edge.
   always @(posedge clock) begin
      logic next_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            verdict_queue.insert(verdict_queue.size(),
                                 classify_query(query_queue.pop_front()));
            if (burst_left > 0)
               burst_left <= burst_left - 1;
            else
               gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         end
         next_valid = 1'b0;
         if (req_tvalid && !req_tready) begin
            next_valid = 1'b1;      // a word on offer stays put
         end else if (gap_left > 0 && !(req_tvalid && burst_left == 0)) begin
            gap_left <= gap_left - 1;
         end else if (query_queue.size() > 0 && !(req_tvalid && burst_left == 0)) begin
            next_valid = 1'b1;
            if (!req_tvalid)
               burst_left <= $urandom_range(40, 0);
         end
         req_tvalid <= next_valid;
         if (next_valid)
            req_tdata <= query_queue[0];
      end
   end

   // Receiver: stall pattern switches between always ready, light random
   // stalls and heavy stalls, each for a random stretch of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 0;
         mode_left  <= 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(2, 0);
            mode_left  <= $urandom_range(200, 10);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(3, 0) != 0);
            default: rsp_tready <= ($urandom_range(3, 0) == 0);
         endcase
      end
   end

   // Checker: every accepted response against the oldest pending verdict.
   always @(posedge clock) begin
      logic [pitt_pkg::RspWidth-1:0] expected;
      logic                          bad;
      bad = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %b", $time, rsp_tdata);
            bad = 1'b1;
         end else begin
            expected = verdict_queue.pop_front();
            if (rsp_tdata[pitt_pkg::HitBit] !== expected[pitt_pkg::HitBit]) begin
               $display("%0t: hit mismatch: expected %b, actual %b",
                        $time, expected[pitt_pkg::HitBit], rsp_tdata[pitt_pkg::HitBit]);
               bad = 1'b1;
            end
            if (rsp_tdata[pitt_pkg::DegenBit] !== expected[pitt_pkg::DegenBit]) begin
               $display("%0t: degenerate mismatch: expected %b, actual %b",
                        $time, expected[pitt_pkg::DegenBit], rsp_tdata[pitt_pkg::DegenBit]);
               bad = 1'b1;
            end
            if (rsp_tdata[pitt_pkg::RspWidth-1:2] !== expected[pitt_pkg::RspWidth-1:2]) begin
               $display("%0t: padding mismatch: expected %b, actual %b",
                        $time, expected[pitt_pkg::RspWidth-1:2],
                        rsp_tdata[pitt_pkg::RspWidth-1:2]);
               bad = 1'b1;
            end
         end
      end
      if (bad)
         error_count <= error_count + 1;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** point_in_triangle_test: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [pitt_pkg::FieldWidth-1:0] tri_a;
      logic [pitt_pkg::FieldWidth-1:0] tri_b;
      logic [pitt_pkg::FieldWidth-1:0] tri_c;
      logic [pitt_pkg::FieldWidth-1:0] up;
      reset = 1'b1;

      tri_a = pack_lanes(0, 0, 0);
      tri_b = pack_lanes(3, 0, 0);
      tri_c = pack_lanes(0, 3, 0);
      up    = pack_lanes(0, 0, 16384);

      // Zero-area triangles: all corners equal, and three collinear corners.
      add_query(pack_lanes(5, 5, 5), pack_lanes(5, 5, 5), pack_lanes(5, 5, 5), up,
                pack_lanes(5, 5, 4));
      add_query(tri_a, pack_lanes(1, 1, 1), pack_lanes(2, 2, 2), up, pack_lanes(1, 0, -1));
      // Zero normal never faces.
      add_query(tri_a, tri_b, tri_c, '0, pack_lanes(1, 1, -1));
      // Point on the plane through the centroid: facing product is zero.
      add_query(tri_a, tri_b, tri_c, up, pack_lanes(1, 1, 0));
      // Facing point inside, and the same point with the normal reversed.
      add_query(tri_a, tri_b, tri_c, up, pack_lanes(1, 1, -1));
      add_query(tri_a, tri_b, tri_c, pack_lanes(0, 0, -16384), pack_lanes(1, 1, -1));
      // On a corner and on an edge: the same-side products are zero.
      add_query(tri_a, tri_b, tri_c, up, pack_lanes(0, 0, -2));
      add_query(tri_a, tri_b, tri_c, up, pack_lanes(2, 0, -2));
      add_query(tri_a, tri_b, tri_c, up, pack_lanes(1, 2, -2));
      // Outside the triangle but facing it.
      add_query(tri_a, tri_b, tri_c, up, pack_lanes(3, 3, -1));
      add_query(tri_a, tri_b, tri_c, up, pack_lanes(-1, 1, -1));
      // Field extremes.
      add_query('0, '0, '0, '0, '0);
      add_query('1, '1, '1, '1, '1);
      add_query({3{16'h8000}}, {3{16'h7FFF}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h7FFF}});
      add_query(pack_lanes(LaneMin, LaneMin, LaneMin), pack_lanes(LaneMax, LaneMin, LaneMin),
                pack_lanes(LaneMin, LaneMax, LaneMin), pack_lanes(0, 0, LaneMin),
                pack_lanes(LaneMin, LaneMin, LaneMax));
      add_query(pack_lanes(LaneMin, LaneMin, LaneMax), pack_lanes(LaneMax, LaneMax, LaneMin),
                pack_lanes(LaneMax, LaneMin, LaneMax), pack_lanes(LaneMax, LaneMin, LaneMax),
                pack_lanes(LaneMin, LaneMax, LaneMin));
      add_query(pack_lanes(LaneMin, 0, 0), pack_lanes(LaneMax, 0, 0), pack_lanes(0, LaneMax, 0),
                pack_lanes(0, 0, LaneMax), pack_lanes(0, 1, LaneMin));
      add_query({3{16'h5555}}, {3{16'hAAAA}}, {16'h5555, 16'hAAAA, 16'h5555},
                {3{16'hAAAA}}, {3{16'h5555}});

      // Mostly shaped queries; the rest are raw random words.
      for (int k = 0; k < 1100; k++) begin
         if ($urandom_range(3, 0) != 0)
            add_shaped_query();
         else
            add_query(rand_field(), rand_field(), rand_field(), rand_field(), rand_field());
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (!(query_queue.size() == 0 && !req_tvalid && verdict_queue.size() == 0))
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (error_count == 0 && verdict_queue.size() == 0) begin
         $display("** point_in_triangle_test: PASSED **");
      end else begin
         $display("** point_in_triangle_test: FAILED **");
      end
      $finish;
   end

endmodule
